// ===== src/icg_pkg.sv =====
package icg_pkg;

  localparam int unsigned CoordInW = 5;
  localparam int unsigned UniW     = 16;
  localparam int unsigned ProbW    = 17;
  localparam int unsigned CntW     = 3;
  localparam int unsigned PartW    = 2;
  localparam int unsigned NumProb  = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned ResW     = 9;
  localparam int unsigned CoordCnt = 1 << CoordInW;
  localparam logic [ProbW-1:0] ProbReset = 17'd32768;

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROB_ZERO_UP  = 3'd0,
    CFG_PROB_ONE_UP   = 3'd1,
    CFG_PROB_TWO_UP   = 3'd2,
    CFG_PROB_THREE_UP = 3'd3,
    CFG_PROB_FOUR_UP  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [PartW-1:0] part_a;
    logic [PartW-1:0] part_b;
    logic [1:0]       side_a;
    logic [1:0]       side_b;
  } nbr_sum_t;

  typedef struct packed {
    logic            spin_a;
    logic            spin_b;
    logic [CntW-1:0] cnt_a;
    logic [CntW-1:0] cnt_b;
  } result_t;

endpackage

// ===== src/icg_ram.sv =====
module icg_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== src/icg_nbr_addr.sv =====
module icg_nbr_addr #(
  parameter int unsigned GRID_SIDE = 32,
  parameter int unsigned COORD_W   = $clog2(GRID_SIDE),
  parameter int unsigned ADDR_W    = 2 * COORD_W
) (
  input  logic [icg_pkg::CoordInW-1:0] row_i,
  input  logic [icg_pkg::CoordInW-1:0] col_i,
  input  logic                         phase_i,
  output logic [ADDR_W-1:0]            site_addr_o,
  output logic [1:0][ADDR_W-1:0]       nbr_addr_o
);

  localparam logic [COORD_W-1:0] Last = COORD_W'(GRID_SIDE - 1);
  localparam logic [COORD_W-1:0] One  = COORD_W'(1);

  logic [COORD_W-1:0] wrap_tab [icg_pkg::CoordCnt];
  logic [COORD_W-1:0] r, c, r_up, r_dn, c_rt, c_lt;

  for (genvar g = 0; g < icg_pkg::CoordCnt; g++) begin : g_wrap
    assign wrap_tab[g] = COORD_W'(g % GRID_SIDE);
  end

  always_comb begin
    r    = wrap_tab[row_i];
    c    = wrap_tab[col_i];
    r_up = (r == Last) ? '0 : r + One;
    r_dn = (r == '0) ? Last : r - One;
    c_rt = (c == Last) ? '0 : c + One;
    c_lt = (c == '0) ? Last : c - One;
    site_addr_o = {r, c};
    if (phase_i) begin
      nbr_addr_o[0] = {r, c_rt};
      nbr_addr_o[1] = {r, c_lt};
    end else begin
      nbr_addr_o[0] = {r_up, c};
      nbr_addr_o[1] = {r_dn, c};
    end
  end

endmodule

// ===== src/icg_decide.sv =====
module icg_decide (
  input  icg_pkg::op_e                                    op_i,
  input  icg_pkg::nbr_sum_t                               nbr_i,
  input  logic                                            load_a_i,
  input  logic                                            load_b_i,
  input  logic [icg_pkg::UniW-1:0]                        uniform_i,
  input  logic [icg_pkg::NumProb-1:0][icg_pkg::ProbW-1:0] prob_i,
  output icg_pkg::result_t                                res_o
);

  logic [icg_pkg::CntW-1:0]  cnt_a, cnt_b;
  logic [icg_pkg::ProbW-1:0] uni_ext, thr_a, thr_b;

  function automatic logic [icg_pkg::ProbW-1:0] pick(
    input logic [icg_pkg::CntW-1:0]                        cnt,
    input logic [icg_pkg::NumProb-1:0][icg_pkg::ProbW-1:0] prob
  );
    logic [icg_pkg::ProbW-1:0] p;
    case (cnt)
      3'd0:    p = prob[0];
      3'd1:    p = prob[1];
      3'd2:    p = prob[2];
      3'd3:    p = prob[3];
      3'd4:    p = prob[4];
      default: p = '0;
    endcase
    return p;
  endfunction

  always_comb begin
    cnt_a = icg_pkg::CntW'(nbr_i.part_a) + icg_pkg::CntW'(nbr_i.side_a[0])
          + icg_pkg::CntW'(nbr_i.side_a[1]);
    cnt_b = icg_pkg::CntW'(nbr_i.part_b) + icg_pkg::CntW'(nbr_i.side_b[0])
          + icg_pkg::CntW'(nbr_i.side_b[1]);
    uni_ext = icg_pkg::ProbW'(uniform_i);
    thr_a   = pick(cnt_a, prob_i);
    thr_b   = pick(cnt_b, prob_i);
    if (op_i == icg_pkg::OP_UPDATE) begin
      res_o.spin_a = uni_ext < thr_a;
      res_o.spin_b = uni_ext < thr_b;
      res_o.cnt_a  = cnt_a;
      res_o.cnt_b  = cnt_b;
    end else begin
      res_o.spin_a = load_a_i;
      res_o.spin_b = load_b_i;
      res_o.cnt_a  = '0;
      res_o.cnt_b  = '0;
    end
  end

endmodule

// ===== src/ising_coupled_gibbs_update_unit.sv =====
// Coupled Gibbs update unit for two wraparound Ising spin grids.
// Input stream (s_axis_*): one item per transfer. tuser carries the op
// (0 load both spins, 1 coupled update); tdata carries row, col, the two
// load spins and the shared Q0.16 uniform. Each item yields one result on
// the output stream (m_axis_*): both new spins, both neighbor up-counts and
// the agreement flag.
// Configuration channel (cfg_*): writes one of the five Q1.16 probability
// registers by index; always ready, write only while the unit is idle.
// Both grids live in one 2-bit wide RAM with two read ports. An item reads
// up/down neighbors on accept and right/left ones in the gather state; the
// next item may be taken in the finish state if the output register is
// empty. A write-back is forwarded to reads of the same site.
// Reset sets all probabilities to one half and empties the pipeline; the
// grids are not cleared and every site must be loaded before an update
// reads it. No clearing pass runs after reset.
// When the receiver stalls, the finished result holds in the output
// register; the unit accepts one more item and holds it ready to write back
// until the output register frees.
module ising_coupled_gibbs_update_unit #(
  parameter int unsigned GRID_SIDE = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // row[4:0], col[9:5], load_spin_a[10], load_spin_b[11], uniform[27:12]
  input  logic [icg_pkg::InDataW-1:0]          s_axis_tdata,
  // op[0]
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // spin_a[0], spin_b[1], up_count_a[4:2], up_count_b[7:5], chains_agree[8]
  output logic [icg_pkg::OutDataW-1:0]         m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [icg_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [icg_pkg::ProbW-1:0]            cfg_data_i
);

  localparam int unsigned CoordW = $clog2(GRID_SIDE);
  localparam int unsigned AddrW  = 2 * CoordW;
  localparam int unsigned Depth  = 1 << AddrW;

  icg_pkg::state_e state_q, state_d;

  logic [icg_pkg::NumProb-1:0][icg_pkg::ProbW-1:0] prob_q;

  icg_pkg::op_e                 op_q;
  logic [icg_pkg::CoordInW-1:0] row_q, col_q;
  logic                         la_q, lb_q;
  logic [icg_pkg::UniW-1:0]     uni_q;
  logic [icg_pkg::PartW-1:0]    part_a_q, part_b_q;
  logic [AddrW-1:0]             site_addr_q;
  logic [1:0][AddrW-1:0]        rd_addr_q;
  logic [AddrW-1:0]             wr_addr_q;
  logic [1:0]                   wr_data_q;
  logic                         wr_vld_q;
  logic                         out_valid_q;
  logic [icg_pkg::ResW-1:0]     out_data_q;

  logic                         accept, finish, rd_en, phase;
  logic [icg_pkg::CoordInW-1:0] sel_row, sel_col;
  logic [AddrW-1:0]             site_addr;
  logic [1:0][AddrW-1:0]        nbr_addr;
  logic [1:0]                   ram_rd0, ram_rd1, fwd0, fwd1;
  icg_pkg::nbr_sum_t            nbr_sum;
  icg_pkg::result_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < icg_pkg::NumProb; k++) begin
        prob_q[k] <= icg_pkg::ProbReset;
      end
    end else if (cfg_valid_i) begin
      case (icg_pkg::cfg_idx_e'(cfg_index_i))
        icg_pkg::CFG_PROB_ZERO_UP:  prob_q[0] <= cfg_data_i;
        icg_pkg::CFG_PROB_ONE_UP:   prob_q[1] <= cfg_data_i;
        icg_pkg::CFG_PROB_TWO_UP:   prob_q[2] <= cfg_data_i;
        icg_pkg::CFG_PROB_THREE_UP: prob_q[3] <= cfg_data_i;
        icg_pkg::CFG_PROB_FOUR_UP:  prob_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      icg_pkg::S_IDLE:   if (accept) state_d = icg_pkg::S_GATHER;
      icg_pkg::S_GATHER: state_d = icg_pkg::S_FINISH;
      icg_pkg::S_FINISH: begin
        if (finish) state_d = accept ? icg_pkg::S_GATHER : icg_pkg::S_IDLE;
      end
      default: state_d = icg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    finish        = 1'b0;
    phase         = 1'b0;
    case (state_q)
      icg_pkg::S_IDLE:   s_axis_tready = 1'b1;
      icg_pkg::S_GATHER: phase = 1'b1;
      icg_pkg::S_FINISH: begin
        finish        = !out_valid_q || m_axis_tready;
        s_axis_tready = !out_valid_q;
      end
      default: ;
    endcase
  end

  assign rd_en = accept || phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= icg_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign sel_row = phase ? row_q : s_axis_tdata[4:0];
  assign sel_col = phase ? col_q : s_axis_tdata[9:5];

  icg_nbr_addr #(
    .GRID_SIDE (GRID_SIDE)
  ) u_nbr_addr (
    .row_i       (sel_row),
    .col_i       (sel_col),
    .phase_i     (phase),
    .site_addr_o (site_addr),
    .nbr_addr_o  (nbr_addr)
  );

  icg_ram #(
    .WIDTH (2),
    .DEPTH (Depth)
  ) u_grid_ram (
    .clk_i    (clk_i),
    .we_i     (finish),
    .waddr_i  (site_addr_q),
    .wdata_i  ({res.spin_b, res.spin_a}),
    .re_i     (rd_en),
    .raddr0_i (nbr_addr[0]),
    .raddr1_i (nbr_addr[1]),
    .rdata0_o (ram_rd0),
    .rdata1_o (ram_rd1)
  );

  assign fwd0 = (wr_vld_q && rd_addr_q[0] == wr_addr_q) ? wr_data_q : ram_rd0;
  assign fwd1 = (wr_vld_q && rd_addr_q[1] == wr_addr_q) ? wr_data_q : ram_rd1;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= icg_pkg::op_e'(s_axis_tuser);
      row_q <= s_axis_tdata[4:0];
      col_q <= s_axis_tdata[9:5];
      la_q  <= s_axis_tdata[10];
      lb_q  <= s_axis_tdata[11];
      uni_q <= s_axis_tdata[27:12];
    end
    if (rd_en) begin
      rd_addr_q <= nbr_addr;
    end
    if (phase) begin
      part_a_q    <= icg_pkg::PartW'(fwd0[0]) + icg_pkg::PartW'(fwd1[0]);
      part_b_q    <= icg_pkg::PartW'(fwd0[1]) + icg_pkg::PartW'(fwd1[1]);
      site_addr_q <= site_addr;
    end
    if (finish) begin
      wr_addr_q  <= site_addr_q;
      wr_data_q  <= {res.spin_b, res.spin_a};
      out_data_q <= {res.spin_a == res.spin_b, res.cnt_b, res.cnt_a,
                     res.spin_b, res.spin_a};
    end
  end

  assign nbr_sum.part_a = part_a_q;
  assign nbr_sum.part_b = part_b_q;
  assign nbr_sum.side_a = {fwd1[0], fwd0[0]};
  assign nbr_sum.side_b = {fwd1[1], fwd0[1]};

  icg_decide u_decide (
    .op_i      (op_q),
    .nbr_i     (nbr_sum),
    .load_a_i  (la_q),
    .load_b_i  (lb_q),
    .uniform_i (uni_q),
    .prob_i    (prob_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      wr_vld_q    <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
        wr_vld_q    <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = icg_pkg::OutDataW'(out_data_q);

`ifndef SYNTHESIS
  a_accept_gathers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == icg_pkg::S_GATHER)
    else $error("accepted item did not start gathering");

  a_gather_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == icg_pkg::S_GATHER |=> state_q == icg_pkg::S_FINISH)
    else $error("gather phase did not advance to finish");

  a_writeback_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q && out_data_q[1:0] == wr_data_q)
    else $error("result does not match written spins");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q[4:2] <= 3'd4 && out_data_q[7:5] <= 3'd4)
    else $error("neighbor count out of range");
`endif

endmodule
